@@ sv/ntds_pkg.sv @@
// Shared types and codes for the NAT type discovery sequencer.
`timescale 1ns / 1ps
`default_nettype none
package ntds_pkg;

    localparam int REG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_SERVER_IP   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SERVER_PORT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOCAL_IP    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOCAL_PORT  = 2'd3;

    localparam logic [15:0] SERVER_PORT_RESET = 16'd3478;

    localparam logic       OP_START   = 1'b0;
    localparam logic       OP_OUTCOME = 1'b1;

    localparam logic [1:0] KIND_SUCCESS = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_XPORT   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOMAP   = 3'd1;
    localparam logic [2:0] ST_ERR     = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_XPORT   = 3'd4;

    localparam logic [9:0] DEFAULT_ERR_CODE = 10'd500;

    localparam logic [1:0] TEST_I   = 2'd0;
    localparam logic [1:0] TEST_II  = 2'd1;
    localparam logic [1:0] TEST_IB  = 2'd2;
    localparam logic [1:0] TEST_III = 2'd3;

    localparam logic [2:0] NAT_UNKNOWN       = 3'd0;
    localparam logic [2:0] NAT_OPEN          = 3'd1;
    localparam logic [2:0] NAT_BLOCKED       = 3'd2;
    localparam logic [2:0] NAT_SYM_UDP       = 3'd3;
    localparam logic [2:0] NAT_FULL_CONE     = 3'd4;
    localparam logic [2:0] NAT_SYMMETRIC     = 3'd5;
    localparam logic [2:0] NAT_RESTRICTED    = 3'd6;
    localparam logic [2:0] NAT_PORT_RESTRICT = 3'd7;

    localparam logic OUT_REQUEST  = 1'b0;
    localparam logic OUT_FINISHED = 1'b1;

    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 72;

    // Classified outcome handed from the front to the back.
    typedef struct packed {
        logic        op;
        logic [2:0]  status;
        logic [9:0]  code;
        logic        has_changed;
        logic [31:0] changed_ip;
        logic [15:0] changed_port;
        logic [31:0] mapped_ip;
        logic [15:0] mapped_port;
        logic        same_local;
    } cls_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [1:0]  test_id;
        logic        change_ip_flag;
        logic        change_port_flag;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [2:0]  nat_class;
        logic [2:0]  status;
        logic [9:0]  err_code_out;
    } result_t;

endpackage
`default_nettype wire

@@ sv/nat_type_discovery_sequencer_unit.sv @@
// Top level of the NAT type discovery sequencer.
//
// Input channel s_*: one item per start or per response outcome; tuser
// carries op and resp_kind, tdata the response attributes. Output channel
// m_*: at most one item per input item, either the next binding request
// (test, change flags, destination) or the final NAT type with a status.
// Outcomes that arrive while no discovery runs produce nothing.
// cfg_wen/cfg_addr/cfg_wdata write the server and local addresses; write
// them only while the block is idle.
// An accepted item is written into the queue at the accept edge; the back
// end then pops it into the result register, which drives m_tvalid. The
// back end decides combinationally and takes one item per cycle while the
// result register is free or being drained.
// When m_tready is low the result register holds and the queue absorbs up
// to QUEUE_DEPTH further items before s_tready drops.
// Reset clears the sequencer to idle, empties the queue and restores the
// default server port.
`timescale 1ns / 1ps
`default_nettype none
module nat_type_discovery_sequencer_unit
    import ntds_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // has_mapped, mapped_ip, mapped_port, has_changed, changed_ip,
    // changed_port, has_err_code, err_code_in, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // op, resp_kind
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // test_id, change_ip_flag, change_port_flag, dest_ip, dest_port,
    // nat_class, status, err_code_out, zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // out_kind
    output logic                        m_tuser,
    input  wire logic                   cfg_wen,
    input  wire logic [REG_IDX_W-1:0]   cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [31:0] server_ip_reg;
    logic [15:0] server_port_reg;
    logic [31:0] local_ip_reg;
    logic [15:0] local_port_reg;

    logic        q_in_valid, q_in_ready;
    cls_item_t   q_in_item;
    logic        q_valid, q_pop;
    cls_item_t   q_item;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_ip_reg   <= '0;
            server_port_reg <= SERVER_PORT_RESET;
            local_ip_reg    <= '0;
            local_port_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_SERVER_IP:   server_ip_reg   <= cfg_wdata;
                REG_SERVER_PORT: server_port_reg <= cfg_wdata[15:0];
                REG_LOCAL_IP:    local_ip_reg    <= cfg_wdata;
                default:         local_port_reg  <= cfg_wdata[15:0];
            endcase
        end
    end

    ntds_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .local_ip   (local_ip_reg),
        .local_port (local_port_reg),
        .q_in_valid (q_in_valid),
        .q_in_ready (q_in_ready),
        .q_in_item  (q_in_item)
    );

    ntds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_item  (q_item)
    );

    ntds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .server_ip   (server_ip_reg),
        .server_port (server_port_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tuser = res.out_kind;
    assign m_tdata = {4'b0, res.err_code_out, res.status, res.nat_class, res.dest_port,
                      res.dest_ip, res.change_port_flag, res.change_ip_flag, res.test_id};

    // a full queue is never empty
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("queue reports full while empty");

    // the back end only takes an item when the result stage can hold its result
    a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!m_tvalid || m_tready))
        else $error("queue popped while result stage stalled");

    // an error code goes out only with an error-response status
    a_err_code_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res.status != ST_ERR)) |-> (res.err_code_out == 10'd0))
        else $error("error code without error status");

    // a request result carries no final type or status
    a_request_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res.out_kind == OUT_REQUEST)) |->
        ((res.nat_class == NAT_UNKNOWN) && (res.status == ST_OK)))
        else $error("request result carries a final type");

endmodule
`default_nettype wire

@@ sv/ntds_front.sv @@
// Front end: unpacks an input item and classifies the response outcome.
`timescale 1ns / 1ps
`default_nettype none
module ntds_front
    import ntds_pkg::*;
(
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic [IN_TUSER_W-1:0] s_tuser,
    input  wire logic [31:0]           local_ip,
    input  wire logic [15:0]           local_port,
    output logic                       q_in_valid,
    input  wire logic                  q_in_ready,
    output cls_item_t                  q_in_item
);

    logic [1:0]  resp_kind;
    logic        has_mapped;
    logic        has_err_code;
    logic [9:0]  err_code_in;

    assign resp_kind    = s_tuser[2:1];
    assign has_mapped   = s_tdata[0];
    assign has_err_code = s_tdata[98];
    assign err_code_in  = s_tdata[108:99];

    assign s_tready   = q_in_ready;
    assign q_in_valid = s_tvalid;

    always_comb
    begin
        q_in_item              = '0;
        q_in_item.op           = s_tuser[0];
        q_in_item.mapped_ip    = s_tdata[32:1];
        q_in_item.mapped_port  = s_tdata[48:33];
        q_in_item.has_changed  = s_tdata[49];
        q_in_item.changed_ip   = s_tdata[81:50];
        q_in_item.changed_port = s_tdata[97:82];
        // user must change local address only while idle; unenforced
        q_in_item.same_local   = (s_tdata[32:1] == local_ip) && (s_tdata[48:33] == local_port);
        unique case (resp_kind)
            KIND_SUCCESS: q_in_item.status = has_mapped ? ST_OK : ST_NOMAP;
            KIND_ERROR:
            begin
                q_in_item.status = ST_ERR;
                q_in_item.code   = has_err_code ? err_code_in : DEFAULT_ERR_CODE;
            end
            KIND_TIMEOUT: q_in_item.status = ST_TIMEOUT;
            default:      q_in_item.status = ST_XPORT;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/ntds_queue.sv @@
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module ntds_queue
    import ntds_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  cls_item_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output cls_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_item_t          slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slots[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

@@ sv/ntds_back.sv @@
// Back end: discovery sequencer state and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none
module ntds_back
    import ntds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] server_ip,
    input  wire logic [15:0] server_port,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  cls_item_t        q_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output result_t          out_res
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_T1   = 3'd1;
    localparam logic [2:0] PH_T2   = 3'd2;
    localparam logic [2:0] PH_T1B  = 3'd3;
    localparam logic [2:0] PH_T3   = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic        same_ip_reg, same_ip_next;
    logic [31:0] first_ip_reg, first_ip_next;
    logic [15:0] first_port_reg, first_port_next;
    logic        alt_valid_reg, alt_valid_next;
    logic [31:0] alt_ip_reg, alt_ip_next;
    logic [15:0] alt_port_reg, alt_port_next;
    logic        out_valid_reg;
    result_t     out_res_reg;
    logic        emit;
    result_t     res;

    function automatic result_t mk_request(logic [1:0] test, logic cip, logic cport,
                                           logic [31:0] ip, logic [15:0] port);
        result_t r;
        r                  = '0;
        r.out_kind         = OUT_REQUEST;
        r.test_id          = test;
        r.change_ip_flag   = cip;
        r.change_port_flag = cport;
        r.dest_ip          = ip;
        r.dest_port        = port;
        return r;
    endfunction

    function automatic result_t mk_finish(logic [2:0] nat, logic [2:0] st, logic [9:0] code);
        result_t r;
        r              = '0;
        r.out_kind     = OUT_FINISHED;
        r.nat_class    = nat;
        r.status       = st;
        r.err_code_out = (st == ST_ERR) ? code : 10'd0;
        return r;
    endfunction

    // advance only when the result stage is free or being drained
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        same_ip_next    = same_ip_reg;
        first_ip_next   = first_ip_reg;
        first_port_next = first_port_reg;
        alt_valid_next  = alt_valid_reg;
        alt_ip_next     = alt_ip_reg;
        alt_port_next   = alt_port_reg;
        emit            = 1'b0;
        res             = '0;
        if (q_pop)
        begin
            if (q_item.op == OP_START)
            begin
                alt_valid_next = 1'b0;
                alt_ip_next    = '0;
                alt_port_next  = '0;
                same_ip_next   = 1'b0;
                phase_next     = PH_T1;
                emit           = 1'b1;
                res            = mk_request(TEST_I, 1'b0, 1'b0, server_ip, server_port);
            end
            else
            begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
                unique case (phase_reg)
                    PH_T1:
                    begin
                        if (q_item.status == ST_OK)
                        begin
                            if (q_item.has_changed)
                            begin
                                alt_valid_next = 1'b1;
                                alt_ip_next    = q_item.changed_ip;
                                alt_port_next  = q_item.changed_port;
                            end
                            first_ip_next   = q_item.mapped_ip;
                            first_port_next = q_item.mapped_port;
                            same_ip_next    = q_item.same_local;
                            phase_next      = PH_T2;
                            res = mk_request(TEST_II, 1'b1, 1'b1, server_ip, server_port);
                        end
                        else if (q_item.status == ST_TIMEOUT)
                        begin
                            res = mk_finish(NAT_BLOCKED, ST_OK, 10'd0);
                        end
                        else
                        begin
                            res = mk_finish(NAT_UNKNOWN, q_item.status, q_item.code);
                        end
                    end
                    PH_T2:
                    begin
                        if (q_item.status == ST_OK)
                        begin
                            res = mk_finish(same_ip_reg ? NAT_OPEN : NAT_FULL_CONE,
                                            ST_OK, 10'd0);
                        end
                        else if (q_item.status == ST_TIMEOUT)
                        begin
                            if (same_ip_reg)
                            begin
                                res = mk_finish(NAT_SYM_UDP, ST_OK, 10'd0);
                            end
                            else if (alt_valid_reg)
                            begin
                                phase_next = PH_T1B;
                                res = mk_request(TEST_IB, 1'b0, 1'b0, alt_ip_reg, alt_port_reg);
                            end
                            else
                            begin
                                res = mk_finish(NAT_UNKNOWN, ST_OK, 10'd0);
                            end
                        end
                        else
                        begin
                            res = mk_finish(NAT_UNKNOWN, q_item.status, q_item.code);
                        end
                    end
                    PH_T1B:
                    begin
                        if (q_item.status == ST_OK)
                        begin
                            if ((q_item.mapped_ip != first_ip_reg) ||
                                (q_item.mapped_port != first_port_reg))
                            begin
                                res = mk_finish(NAT_SYMMETRIC, ST_OK, 10'd0);
                            end
                            else
                            begin
                                phase_next = PH_T3;
                                res = mk_request(TEST_III, 1'b0, 1'b1, server_ip, server_port);
                            end
                        end
                        else
                        begin
                            res = mk_finish(NAT_UNKNOWN, q_item.status, q_item.code);
                        end
                    end
                    PH_T3:
                    begin
                        if (q_item.status == ST_OK)
                        begin
                            res = mk_finish(NAT_RESTRICTED, ST_OK, 10'd0);
                        end
                        else if (q_item.status == ST_TIMEOUT)
                        begin
                            res = mk_finish(NAT_PORT_RESTRICT, ST_OK, 10'd0);
                        end
                        else
                        begin
                            res = mk_finish(NAT_UNKNOWN, q_item.status, q_item.code);
                        end
                    end
                    default:
                    begin
                        // outcome with nothing outstanding: drop it
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            same_ip_reg    <= 1'b0;
            first_ip_reg   <= '0;
            first_port_reg <= '0;
            alt_valid_reg  <= 1'b0;
            alt_ip_reg     <= '0;
            alt_port_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            same_ip_reg    <= same_ip_next;
            first_ip_reg   <= first_ip_next;
            first_port_reg <= first_port_next;
            alt_valid_reg  <= alt_valid_next;
            alt_ip_reg     <= alt_ip_next;
            alt_port_reg   <= alt_port_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_res_reg <= res;
        end
    end

endmodule
`default_nettype wire
